[hw/rtl/rtu_ftc_pkg.sv]
// Shared types, codes and helpers for the RTU frame timing controller.
// No dependencies; used by rtu_frame_timing_controller.
package rtu_ftc_pkg;

    // Frame size limits
    localparam int MAX_FRAME_BYTES_DEF = 256;
    localparam int MIN_FRAME_BYTES     = 8;

    // Field widths
    localparam int KIND_W   = 3;
    localparam int BYTE_W   = 8;
    localparam int TICK_W   = 16;
    localparam int LEN_W    = 9;
    localparam int EVENT_W  = 3;
    localparam int STATE_W  = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 32;

    // Register reset values
    localparam logic [BYTE_W-1:0] OWN_ADDRESS_RST = 8'd1;
    localparam logic [TICK_W-1:0] END_GAP_RST     = 16'd149;
    localparam logic [TICK_W-1:0] TURNAROUND_RST  = 16'd116;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_GAP     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TURNAROUND  = 2'd2;

    // Input request kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_TICK     = 3'd0,
        KIND_RX_BYTE  = 3'd1,
        KIND_SEND     = 3'd2,
        KIND_TX_READY = 3'd3,
        KIND_RESUME   = 3'd4
    } kind_t;

    // Result events
    typedef enum logic [EVENT_W-1:0] {
        EV_NONE        = 3'd0,
        EV_BYTE_STORED = 3'd1,
        EV_FRAME_READY = 3'd2,
        EV_FETCH_TX    = 3'd3,
        EV_LINE_ERROR  = 3'd4,
        EV_REJECTED    = 3'd5,
        EV_TX_DONE     = 3'd6
    } event_t;

    // Link state, one-hot
    typedef enum logic [6:0] {
        MODE_SYNC = 7'b0000001,
        MODE_IDLE = 7'b0000010,
        MODE_RX   = 7'b0000100,
        MODE_HELD = 7'b0001000,
        MODE_PRE  = 7'b0010000,
        MODE_BODY = 7'b0100000,
        MODE_POST = 7'b1000000
    } mode_t;

    // Link state codes as reported on the result stream
    localparam logic [STATE_W-1:0] LS_SYNC = 3'd0;
    localparam logic [STATE_W-1:0] LS_IDLE = 3'd1;
    localparam logic [STATE_W-1:0] LS_RX   = 3'd2;
    localparam logic [STATE_W-1:0] LS_HELD = 3'd3;
    localparam logic [STATE_W-1:0] LS_PRE  = 3'd4;
    localparam logic [STATE_W-1:0] LS_BODY = 3'd5;
    localparam logic [STATE_W-1:0] LS_POST = 3'd6;

    // Map the one-hot mode to its reported code
    function automatic logic [STATE_W-1:0] mode_code(input mode_t m);
        logic [STATE_W-1:0] c;
        case (m)
            MODE_SYNC: c = LS_SYNC;
            MODE_IDLE: c = LS_IDLE;
            MODE_RX:   c = LS_RX;
            MODE_HELD: c = LS_HELD;
            MODE_PRE:  c = LS_PRE;
            MODE_BODY: c = LS_BODY;
            MODE_POST: c = LS_POST;
            default:   c = LS_SYNC;
        endcase
        return c;
    endfunction

endpackage

[hw/rtl/rtu_frame_timing_controller.sv]
// RTU frame timing controller: link state machine, silence timer and
// turnaround sequencing for a slave-side serial link. Depends on rtu_ftc_pkg.
//
// A result is registered and appears on the master side in the cycle after its request
// is taken. Throughput: one request per cycle; the single output register
// stalls the input only while a result waits and the master side is not ready.
// Reset (rst_n low, asynchronous): link in sync, timer and counters cleared,
// driver off, registers at their defaults, output stream empty.
module rtu_frame_timing_controller #(
    parameter int MAX_FRAME_BYTES = rtu_ftc_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write port
    input  logic                                cfg_we,
    input  logic [rtu_ftc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rtu_ftc_pkg::CFG_DATA_W-1:0]  cfg_data,
    // Request stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: rx_data[7:0], framing_error[8], parity_error[9], send_length[17:10], zero
    input  logic [rtu_ftc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // tuser: kind[2:0]
    input  logic [rtu_ftc_pkg::KIND_W-1:0]      s_axis_tuser,
    // Result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: byte_index[7:0], byte_value[15:8], frame_length[24:16],
    //        driver_enable[25], link_state[28:26], zero
    output logic [rtu_ftc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // tuser: event_res[2:0]
    output logic [rtu_ftc_pkg::EVENT_W-1:0]     m_axis_tuser
);

    localparam int RX_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int BW   = rtu_ftc_pkg::BYTE_W;
    localparam int TW   = rtu_ftc_pkg::TICK_W;
    localparam int LW   = rtu_ftc_pkg::LEN_W;

    // Configuration registers
    logic [BW-1:0] own_address_reg;
    logic [TW-1:0] end_gap_reg;
    logic [TW-1:0] turnaround_reg;

    // Link state
    rtu_ftc_pkg::mode_t mode_reg, mode_next;
    logic [TW-1:0]   tick_count_reg, tick_count_next;
    logic            gap_armed_reg, gap_armed_next;
    logic [RX_W-1:0] rx_count_reg, rx_count_next;
    logic [BW-1:0]   first_byte_reg, first_byte_next;
    logic [BW-1:0]   tx_remaining_reg, tx_remaining_next;
    logic [BW-1:0]   tx_position_reg, tx_position_next;
    logic            driver_on_reg, driver_on_next;

    // Output register
    logic                       out_valid_reg;
    rtu_ftc_pkg::event_t        ev_reg, ev_next;
    logic [BW-1:0]              idx_reg, idx_next;
    logic [BW-1:0]              val_reg, val_next;
    logic [LW-1:0]              len_reg, len_next;

    // Request fields
    rtu_ftc_pkg::kind_t kind;
    logic [BW-1:0]      rx_data;
    logic               bad_byte;
    logic [BW-1:0]      send_length;
    logic               accept;

    logic [TW:0]        tick_inc;
    logic [TW-1:0]      tick_cmp;
    logic               tx_phase;
    logic               late_byte;
    logic [LW-1:0]      rx_ext;

    assign kind        = rtu_ftc_pkg::kind_t'(s_axis_tuser);
    assign rx_data     = s_axis_tdata[7:0];
    assign bad_byte    = s_axis_tdata[8] | s_axis_tdata[9];
    assign send_length = s_axis_tdata[17:10];

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign tx_phase = (mode_reg == rtu_ftc_pkg::MODE_PRE) ||
                      (mode_reg == rtu_ftc_pkg::MODE_BODY) ||
                      (mode_reg == rtu_ftc_pkg::MODE_POST);
    assign tick_cmp = tx_phase ? turnaround_reg : end_gap_reg;
    assign tick_inc = {1'b0, tick_count_reg} + {{TW{1'b0}}, 1'b1};
    assign rx_ext   = LW'(rx_count_reg);
    assign late_byte = (mode_reg == rtu_ftc_pkg::MODE_RX) && (tick_count_reg >= end_gap_reg);

    // Next link state and result for one request
    always_comb
    begin
        mode_next         = mode_reg;
        tick_count_next   = tick_count_reg;
        gap_armed_next    = gap_armed_reg;
        rx_count_next     = rx_count_reg;
        first_byte_next   = first_byte_reg;
        tx_remaining_next = tx_remaining_reg;
        tx_position_next  = tx_position_reg;
        driver_on_next    = driver_on_reg;
        ev_next           = rtu_ftc_pkg::EV_NONE;
        idx_next          = '0;
        val_next          = '0;
        len_next          = '0;

        case (kind)
            rtu_ftc_pkg::KIND_TICK:
            begin
                if (tick_inc >= {1'b0, tick_cmp})
                begin
                    tick_count_next = '0;
                    if (gap_armed_reg)
                    begin
                        // Silence gap elapsed: advance the link
                        gap_armed_next = 1'b0;
                        case (mode_reg)
                            rtu_ftc_pkg::MODE_SYNC:
                            begin
                                mode_next     = rtu_ftc_pkg::MODE_IDLE;
                                rx_count_next = '0;
                            end
                            rtu_ftc_pkg::MODE_RX:
                            begin
                                if (rx_ext < LW'(rtu_ftc_pkg::MIN_FRAME_BYTES) ||
                                    (first_byte_reg != own_address_reg &&
                                     first_byte_reg != '0))
                                begin
                                    mode_next     = rtu_ftc_pkg::MODE_IDLE;
                                    rx_count_next = '0;
                                    ev_next       = rtu_ftc_pkg::EV_REJECTED;
                                end
                                else
                                begin
                                    mode_next = rtu_ftc_pkg::MODE_HELD;
                                    len_next  = rx_ext;
                                    ev_next   = rtu_ftc_pkg::EV_FRAME_READY;
                                end
                            end
                            rtu_ftc_pkg::MODE_PRE:
                            begin
                                mode_next = rtu_ftc_pkg::MODE_BODY;
                            end
                            rtu_ftc_pkg::MODE_POST:
                            begin
                                driver_on_next = 1'b0;
                                mode_next      = rtu_ftc_pkg::MODE_IDLE;
                                rx_count_next  = '0;
                                ev_next        = rtu_ftc_pkg::EV_TX_DONE;
                            end
                            default:
                            begin
                                mode_next      = rtu_ftc_pkg::MODE_SYNC;
                                rx_count_next  = '0;
                                gap_armed_next = 1'b1;
                            end
                        endcase
                    end
                end
                else
                begin
                    tick_count_next = tick_inc[TW-1:0];
                end
            end
            rtu_ftc_pkg::KIND_RX_BYTE:
            begin
                if (mode_reg == rtu_ftc_pkg::MODE_SYNC)
                begin
                    // Restart the silence count
                    rx_count_next   = '0;
                    tick_count_next = '0;
                    gap_armed_next  = 1'b1;
                end
                else if (mode_reg == rtu_ftc_pkg::MODE_IDLE ||
                         mode_reg == rtu_ftc_pkg::MODE_RX)
                begin
                    tick_count_next = '0;
                    gap_armed_next  = 1'b1;
                    if (bad_byte || late_byte ||
                        rx_count_reg >= RX_W'(MAX_FRAME_BYTES))
                    begin
                        mode_next     = rtu_ftc_pkg::MODE_SYNC;
                        rx_count_next = '0;
                        ev_next       = rtu_ftc_pkg::EV_LINE_ERROR;
                    end
                    else
                    begin
                        if (rx_count_reg == '0)
                        begin
                            first_byte_next = rx_data;
                        end
                        mode_next     = rtu_ftc_pkg::MODE_RX;
                        ev_next       = rtu_ftc_pkg::EV_BYTE_STORED;
                        idx_next      = rx_ext[BW-1:0];
                        val_next      = rx_data;
                        rx_count_next = rx_count_reg + RX_W'(1);
                    end
                end
            end
            rtu_ftc_pkg::KIND_SEND:
            begin
                if (mode_reg == rtu_ftc_pkg::MODE_HELD)
                begin
                    tick_count_next   = '0;
                    driver_on_next    = 1'b1;
                    mode_next         = rtu_ftc_pkg::MODE_PRE;
                    gap_armed_next    = 1'b1;
                    tx_remaining_next = send_length;
                    tx_position_next  = '0;
                end
            end
            rtu_ftc_pkg::KIND_TX_READY:
            begin
                if (mode_reg == rtu_ftc_pkg::MODE_BODY)
                begin
                    if (tx_remaining_reg != '0)
                    begin
                        tx_remaining_next = tx_remaining_reg - BW'(1);
                        ev_next           = rtu_ftc_pkg::EV_FETCH_TX;
                        idx_next          = tx_position_reg;
                        tx_position_next  = tx_position_reg + BW'(1);
                    end
                    else
                    begin
                        mode_next       = rtu_ftc_pkg::MODE_POST;
                        tick_count_next = '0;
                        gap_armed_next  = 1'b1;
                    end
                end
            end
            rtu_ftc_pkg::KIND_RESUME:
            begin
                if (mode_reg == rtu_ftc_pkg::MODE_HELD)
                begin
                    mode_next     = rtu_ftc_pkg::MODE_IDLE;
                    rx_count_next = '0;
                end
            end
            default:
            begin
                ev_next = rtu_ftc_pkg::EV_NONE;
            end
        endcase
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_address_reg <= rtu_ftc_pkg::OWN_ADDRESS_RST;
            end_gap_reg     <= rtu_ftc_pkg::END_GAP_RST;
            turnaround_reg  <= rtu_ftc_pkg::TURNAROUND_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rtu_ftc_pkg::CFG_OWN_ADDRESS: own_address_reg <= cfg_data[BW-1:0];
                rtu_ftc_pkg::CFG_END_GAP:     end_gap_reg     <= cfg_data;
                rtu_ftc_pkg::CFG_TURNAROUND:  turnaround_reg  <= cfg_data;
                default:                      own_address_reg <= own_address_reg;
            endcase
        end
    end

    // Link state: advance on each accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= rtu_ftc_pkg::MODE_SYNC;
            tick_count_reg   <= '0;
            gap_armed_reg    <= 1'b1;
            rx_count_reg     <= '0;
            first_byte_reg   <= '0;
            tx_remaining_reg <= '0;
            tx_position_reg  <= '0;
            driver_on_reg    <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg         <= mode_next;
            tick_count_reg   <= tick_count_next;
            gap_armed_reg    <= gap_armed_next;
            rx_count_reg     <= rx_count_next;
            first_byte_reg   <= first_byte_next;
            tx_remaining_reg <= tx_remaining_next;
            tx_position_reg  <= tx_position_next;
            driver_on_reg    <= driver_on_next;
        end
    end

    // Output register valid: load on accept, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    logic               drv_out_reg;
    logic [rtu_ftc_pkg::STATE_W-1:0] state_out_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ev_reg        <= ev_next;
            idx_reg       <= idx_next;
            val_reg       <= val_next;
            len_reg       <= len_next;
            drv_out_reg   <= driver_on_next;
            state_out_reg <= rtu_ftc_pkg::mode_code(mode_next);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = ev_reg;
    assign m_axis_tdata  = {3'b000, state_out_reg, drv_out_reg, len_reg, val_reg, idx_reg};

    // Driver is on exactly through the transmit phases
    a_driver_phase: assert property (@(posedge clk) disable iff (!rst_n)
        driver_on_reg == tx_phase)
        else $error("driver enable out of step with link state");

    // Timer never reaches all ones: it wraps at the compare value
    a_tick_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tick_count_reg != {TW{1'b1}})
        else $error("tick counter overran");

    // Stored byte count stays within the frame limit
    a_rx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rx_count_reg <= RX_W'(MAX_FRAME_BYTES))
        else $error("receive count beyond frame limit");

    // A frame handed over is long enough and leaves the link held
    a_frame_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == rtu_ftc_pkg::EV_FRAME_READY) |->
        (m_axis_tdata[24:16] >= LW'(rtu_ftc_pkg::MIN_FRAME_BYTES) &&
         m_axis_tdata[28:26] == rtu_ftc_pkg::LS_HELD))
        else $error("frame ready with short length or wrong state");

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
// Testbench for rtu_frame_timing_controller: streams ticks, bytes and reply commands,
// predicts every result in a scoreboard class and compares field by field.
// Depends on rtu_ftc_pkg and the controller RTL only.
module tb;

    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_OFF    = 300;

    typedef struct packed {
        rtu_ftc_pkg::event_t ev;
        logic [7:0]          idx;
        logic [7:0]          val;
        logic [8:0]          len;
        logic                drv;
        logic [2:0]          ls;
    } link_result_t;

    // Scoreboard: own copy of the link state machine and the results it owes
    class frame_timing_scoreboard;
        logic [7:0]   own_addr;
        logic [15:0]  end_gap;
        logic [15:0]  turnaround;
        logic [2:0]   mode;
        logic [15:0]  ticks;
        bit           armed;
        logic [8:0]   rx_cnt;
        logic [7:0]   first_rx;
        logic [7:0]   tx_left;
        logic [7:0]   tx_pos;
        bit           drv_on;
        link_result_t due_results[$];
        int           mismatches;
        int           checked;
        int           requests;
        int           ev_count[8];

        function new();
            own_addr   = rtu_ftc_pkg::OWN_ADDRESS_RST;
            end_gap    = rtu_ftc_pkg::END_GAP_RST;
            turnaround = rtu_ftc_pkg::TURNAROUND_RST;
            mode       = rtu_ftc_pkg::LS_SYNC;
            ticks      = '0;
            armed      = 1'b1;
            rx_cnt     = '0;
            first_rx   = '0;
            tx_left    = '0;
            tx_pos     = '0;
            drv_on     = 1'b0;
            mismatches = 0;
            checked    = 0;
            requests   = 0;
            foreach (ev_count[i]) ev_count[i] = 0;
        endfunction

        function void set_reg(logic [rtu_ftc_pkg::CFG_IDX_W-1:0] idx,
                              logic [rtu_ftc_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                rtu_ftc_pkg::CFG_OWN_ADDRESS: own_addr = data[7:0];
                rtu_ftc_pkg::CFG_END_GAP:     end_gap = data;
                rtu_ftc_pkg::CFG_TURNAROUND:  turnaround = data;
                default: ;
            endcase
        endfunction

        function void enter_sync();
            rx_cnt = '0;
            ticks  = '0;
            armed  = 1'b1;
            mode   = rtu_ftc_pkg::LS_SYNC;
        endfunction

        function void enter_idle();
            rx_cnt = '0;
            mode   = rtu_ftc_pkg::LS_IDLE;
        endfunction

        function int pending_count();
            return due_results.size();
        endfunction

        // Advance the link model by one accepted request and queue its result
        function void take_request(rtu_ftc_pkg::kind_t kind, logic [7:0] data, logic fe,
                                   logic pe, logic [7:0] slen);
            link_result_t r;
            logic [15:0]  cmp;
            logic [16:0]  nxt;
            bit           late;
            r = '0;
            r.ev = rtu_ftc_pkg::EV_NONE;
            case (kind)
                rtu_ftc_pkg::KIND_TICK:
                begin
                    cmp = (mode >= rtu_ftc_pkg::LS_PRE) ? turnaround : end_gap;
                    nxt = {1'b0, ticks} + 17'd1;
                    if (nxt >= {1'b0, cmp})
                    begin
                        ticks = '0;
                        if (armed)
                        begin
                            armed = 1'b0;
                            case (mode)
                                rtu_ftc_pkg::LS_SYNC: enter_idle();
                                rtu_ftc_pkg::LS_RX:
                                begin
                                    if (rx_cnt < rtu_ftc_pkg::MIN_FRAME_BYTES ||
                                        (first_rx != own_addr && first_rx != 8'h00))
                                    begin
                                        enter_idle();
                                        r.ev = rtu_ftc_pkg::EV_REJECTED;
                                    end
                                    else
                                    begin
                                        mode  = rtu_ftc_pkg::LS_HELD;
                                        r.len = rx_cnt;
                                        r.ev  = rtu_ftc_pkg::EV_FRAME_READY;
                                    end
                                end
                                rtu_ftc_pkg::LS_PRE: mode = rtu_ftc_pkg::LS_BODY;
                                rtu_ftc_pkg::LS_POST:
                                begin
                                    drv_on = 1'b0;
                                    enter_idle();
                                    r.ev = rtu_ftc_pkg::EV_TX_DONE;
                                end
                                default: enter_sync();
                            endcase
                        end
                    end
                    else
                    begin
                        ticks = nxt[15:0];
                    end
                end
                rtu_ftc_pkg::KIND_RX_BYTE:
                begin
                    if (mode == rtu_ftc_pkg::LS_SYNC)
                    begin
                        enter_sync();
                    end
                    else if (mode == rtu_ftc_pkg::LS_IDLE || mode == rtu_ftc_pkg::LS_RX)
                    begin
                        late  = (mode == rtu_ftc_pkg::LS_RX) && (ticks >= end_gap);
                        ticks = '0;
                        armed = 1'b1;
                        if (fe || pe || late || rx_cnt >= rtu_ftc_pkg::MAX_FRAME_BYTES_DEF)
                        begin
                            enter_sync();
                            r.ev = rtu_ftc_pkg::EV_LINE_ERROR;
                        end
                        else
                        begin
                            if (rx_cnt == 9'd0) first_rx = data;
                            mode   = rtu_ftc_pkg::LS_RX;
                            r.ev   = rtu_ftc_pkg::EV_BYTE_STORED;
                            r.idx  = rx_cnt[7:0];
                            r.val  = data;
                            rx_cnt = rx_cnt + 9'd1;
                        end
                    end
                end
                rtu_ftc_pkg::KIND_SEND:
                begin
                    if (mode == rtu_ftc_pkg::LS_HELD)
                    begin
                        ticks   = '0;
                        drv_on  = 1'b1;
                        mode    = rtu_ftc_pkg::LS_PRE;
                        armed   = 1'b1;
                        tx_left = slen;
                        tx_pos  = '0;
                    end
                end
                rtu_ftc_pkg::KIND_TX_READY:
                begin
                    if (mode == rtu_ftc_pkg::LS_BODY)
                    begin
                        if (tx_left != 8'd0)
                        begin
                            tx_left = tx_left - 8'd1;
                            r.ev    = rtu_ftc_pkg::EV_FETCH_TX;
                            r.idx   = tx_pos;
                            tx_pos  = tx_pos + 8'd1;
                        end
                        else
                        begin
                            mode  = rtu_ftc_pkg::LS_POST;
                            ticks = '0;
                            armed = 1'b1;
                        end
                    end
                end
                rtu_ftc_pkg::KIND_RESUME:
                begin
                    if (mode == rtu_ftc_pkg::LS_HELD) enter_idle();
                end
                default: ;
            endcase
            r.drv = drv_on;
            r.ls  = mode;
            requests++;
            ev_count[int'(r.ev)]++;
            due_results.push_back(r);
        endfunction

        task report(string msg);
            mismatches++;
            $display("MISMATCH result %0d: %s", checked, msg);
        endtask

        // Compare one accepted result with the oldest prediction
        task check_result(logic [rtu_ftc_pkg::OUT_DATA_W-1:0] data,
                          logic [rtu_ftc_pkg::EVENT_W-1:0] user);
            link_result_t want;
            if (due_results.size() == 0)
            begin
                report($sformatf("event %0d arrived with nothing outstanding", user));
            end
            else
            begin
                want = due_results.pop_front();
                checked++;
                if (user !== want.ev)
                    report($sformatf("event got %0d want %0d", user, want.ev));
                if (data[7:0] !== want.idx)
                    report($sformatf("byte_index got %0d want %0d", data[7:0], want.idx));
                if (data[15:8] !== want.val)
                    report($sformatf("byte_value got %0h want %0h", data[15:8], want.val));
                if (data[24:16] !== want.len)
                    report($sformatf("frame_length got %0d want %0d", data[24:16], want.len));
                if (data[25] !== want.drv)
                    report($sformatf("driver_enable got %0b want %0b", data[25], want.drv));
                if (data[28:26] !== want.ls)
                    report($sformatf("link_state got %0d want %0d", data[28:26], want.ls));
                if (data[31:29] !== 3'b000)
                    report($sformatf("tdata padding got %0b", data[31:29]));
            end
        endtask
    endclass

    logic                                clk = 1'b0;
    logic                                rst_n;
    logic                                cfg_we;
    logic [rtu_ftc_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [rtu_ftc_pkg::CFG_DATA_W-1:0]  cfg_data;
    logic                                s_axis_tvalid;
    logic                                s_axis_tready;
    logic [rtu_ftc_pkg::IN_DATA_W-1:0]   s_axis_tdata;
    logic [rtu_ftc_pkg::KIND_W-1:0]      s_axis_tuser;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready;
    logic [rtu_ftc_pkg::OUT_DATA_W-1:0]  m_axis_tdata;
    logic [rtu_ftc_pkg::EVENT_W-1:0]     m_axis_tuser;

    frame_timing_scoreboard sb = new();

    logic [7:0]  cur_own  = rtu_ftc_pkg::OWN_ADDRESS_RST;
    logic [15:0] cur_gap  = rtu_ftc_pkg::END_GAP_RST;
    logic [15:0] cur_turn = rtu_ftc_pkg::TURNAROUND_RST;
    int          request_total = 0;
    int          sink_hold_req = 0;
    bit          src_idle_on = 1'b1;
    bit          dst_idle_on = 1'b1;
    int          quiet_cycles = 0;

    rtu_frame_timing_controller dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #4 clk = ~clk;

    // Check every result taken on the master side
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no request or result moved for %0d cycles", STALL_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Result sink: random back-pressure bursts and the long hold-off
    initial
    begin : result_sink
        int n;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (sink_hold_req > 0)
            begin
                n = sink_hold_req;
                sink_hold_req = 0;
                m_axis_tready <= 1'b0;
                repeat (n - 1) @(negedge clk);
            end
            else if (dst_idle_on && $urandom_range(0, 7) == 0)
            begin
                n = $urandom_range(1, 12);
                m_axis_tready <= 1'b0;
                repeat (n - 1) @(negedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    function automatic logic [7:0] rnd8();
        return 8'($urandom_range(0, 255));
    endfunction

    // Offer one request and hold it until taken; leaves tvalid high at a falling edge
    task automatic push_request(rtu_ftc_pkg::kind_t kind, logic [7:0] data, logic fe,
                                logic pe, logic [7:0] slen);
        if (src_idle_on && $urandom_range(0, 7) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {6'd0, slen, pe, fe, data};
        do @(posedge clk); while (!s_axis_tready);
        sb.take_request(kind, data, fe, pe, slen);
        request_total++;
        @(negedge clk);
    endtask

    task automatic ticks(int n);
        repeat (n)
            push_request(rtu_ftc_pkg::KIND_TICK, rnd8(), 1'($urandom), 1'($urandom), rnd8());
    endtask

    task automatic noise(int n);
        repeat (n)
            push_request(rtu_ftc_pkg::kind_t'(3'($urandom_range(0, 4))), rnd8(),
                         1'($urandom), 1'($urandom), rnd8());
    endtask

    // Send a frame; messy frames get line errors and inter-byte silence mixed in
    task automatic rx_frame(int n, logic [7:0] first_val, bit messy);
        int   sel;
        logic fe;
        logic pe;
        for (int i = 0; i < n; i++)
        begin
            fe = 1'b0;
            pe = 1'b0;
            if (messy && $urandom_range(0, 24) == 0)
            begin
                sel = $urandom_range(1, 3);
                fe  = sel[0];
                pe  = sel[1];
            end
            push_request(rtu_ftc_pkg::KIND_RX_BYTE, (i == 0) ? first_val : rnd8(), fe, pe,
                         rnd8());
            if (messy)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 15 && cur_gap > 1)
                    ticks($urandom_range(1, cur_gap - 1));
                else if (sel < 18)
                    ticks(cur_gap);
            end
        end
    endtask

    // Reply sequence: send request, preamble, body fetches, postamble
    task automatic reply(int slen);
        push_request(rtu_ftc_pkg::KIND_SEND, rnd8(), 1'($urandom), 1'($urandom), 8'(slen));
        ticks(cur_turn);
        repeat (slen + 1)
        begin
            if ($urandom_range(0, 4) == 0) ticks(1);
            push_request(rtu_ftc_pkg::KIND_TX_READY, rnd8(), 1'($urandom), 1'($urandom),
                         rnd8());
        end
        ticks(cur_turn);
        if ($urandom_range(0, 3) == 0)
            push_request(rtu_ftc_pkg::KIND_TX_READY, rnd8(), 1'($urandom), 1'($urandom),
                         rnd8());
    endtask

    // One master/slave exchange: silence, frame, end gap, then reply, resume or noise
    task automatic exchange(int force_len);
        int         n;
        int         pick;
        logic [7:0] first_val;
        ticks(cur_gap + $urandom_range(0, 2));
        pick = $urandom_range(0, 99);
        if (force_len >= 0)  n = force_len;
        else if (pick < 15)  n = $urandom_range(1, 7);
        else                 n = $urandom_range(8, 16);
        pick = $urandom_range(0, 99);
        if (pick < 55)      first_val = cur_own;
        else if (pick < 75) first_val = 8'h00;
        else                first_val = rnd8();
        rx_frame(n, first_val, force_len < 0);
        ticks(cur_gap);
        pick = $urandom_range(0, 99);
        if (pick < 70)
            reply(($urandom_range(0, 49) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6));
        else if (pick < 85)
            push_request(rtu_ftc_pkg::KIND_RESUME, rnd8(), 1'($urandom), 1'($urandom), rnd8());
        else
            noise($urandom_range(1, 6));
    endtask

    // Stop offering and wait until every predicted result has arrived
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_count() != 0) @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    // Drain, then write all three registers on consecutive cycles
    task automatic apply_config(logic [7:0] own, logic [15:0] gap, logic [15:0] turn);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= rtu_ftc_pkg::CFG_OWN_ADDRESS;
        cfg_data  <= {8'h00, own};
        @(negedge clk);
        cfg_index <= rtu_ftc_pkg::CFG_END_GAP;
        cfg_data  <= gap;
        @(negedge clk);
        cfg_index <= rtu_ftc_pkg::CFG_TURNAROUND;
        cfg_data  <= turn;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(rtu_ftc_pkg::CFG_OWN_ADDRESS, {8'h00, own});
        sb.set_reg(rtu_ftc_pkg::CFG_END_GAP, gap);
        sb.set_reg(rtu_ftc_pkg::CFG_TURNAROUND, turn);
        cur_own  = own;
        cur_gap  = gap;
        cur_turn = turn;
    endtask

    task automatic run_phase(int target);
        int start;
        start = request_total;
        while (request_total - start < target)
        begin
            if ($urandom_range(0, 9) == 0) noise($urandom_range(1, 8));
            else exchange(-1);
        end
    endtask

    initial
    begin : stimulus
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset register values: one full exchange at the default timing
        ticks(cur_gap);
        rx_frame(8, cur_own, 1'b0);
        ticks(cur_gap);
        reply(2);

        // Directed cases at short timing
        apply_config(8'h5A, 16'd3, 16'd2);
        ticks(1);
        // byte in idle starts a one-byte frame that the silence rejects as too short
        push_request(rtu_ftc_pkg::KIND_RX_BYTE, 8'h00, 1'b0, 1'b0, 8'h00);
        ticks(3);
        // framing error
        push_request(rtu_ftc_pkg::KIND_RX_BYTE, 8'hFF, 1'b1, 1'b0, 8'hFF);
        ticks(3);
        push_request(rtu_ftc_pkg::KIND_RX_BYTE, 8'h5A, 1'b0, 1'b0, 8'h00);
        // parity error mid-frame
        push_request(rtu_ftc_pkg::KIND_RX_BYTE, 8'h11, 1'b0, 1'b1, 8'h00);
        ticks(3);
        rx_frame(3, 8'h5A, 1'b0);                                // too short
        ticks(3);
        rx_frame(8, 8'hFF, 1'b0);                                // someone else's address
        ticks(3);
        rx_frame(7, 8'h00, 1'b0);                                // broadcast
        push_request(rtu_ftc_pkg::KIND_RX_BYTE, 8'hFF, 1'b0, 1'b0, 8'hFF);
        ticks(3);
        // receiver off while held
        push_request(rtu_ftc_pkg::KIND_RX_BYTE, 8'h33, 1'b0, 1'b0, 8'h00);
        push_request(rtu_ftc_pkg::KIND_TX_READY, 8'h00, 1'b0, 1'b0, 8'h00);
        reply(0);                                                // empty body
        // send and resume are ignored outside held
        push_request(rtu_ftc_pkg::KIND_SEND, 8'h00, 1'b0, 1'b0, 8'h05);
        push_request(rtu_ftc_pkg::KIND_RESUME, 8'h00, 1'b0, 1'b0, 8'h00);
        rx_frame(8, 8'h5A, 1'b0);
        ticks(3);
        // drop held frame
        push_request(rtu_ftc_pkg::KIND_RESUME, 8'h00, 1'b0, 1'b0, 8'h00);
        rx_frame(2, 8'h5A, 1'b0);
        ticks(2);
        apply_config(8'h5A, 16'd1, 16'd2);                       // gap now already run out
        push_request(rtu_ftc_pkg::KIND_RX_BYTE, 8'h44, 1'b0, 1'b0, 8'h00);

        // Lowest timing values
        apply_config(rnd8(), 16'd1, 16'd1);
        run_phase(60);

        // Long hold-off on the result side while requests keep coming
        apply_config(8'hFF, 16'($urandom_range(2, 8)), 16'($urandom_range(1, 6)));
        sink_hold_req = HOLD_OFF;
        ticks(40);
        run_phase(50);
        drain_results();
        run_phase(30);

        // Broadcast-only address and frames at the size limit
        apply_config(8'h00, 16'd4, 16'd3);
        exchange(256);
        exchange(257);
        run_phase(40);

        // Highest timing values: the gaps never run out here
        apply_config(rnd8(), 16'hFFFF, 16'hFFFF);
        repeat (4)
        begin
            rx_frame($urandom_range(1, 9), rnd8(), 1'b0);
            ticks($urandom_range(0, 30));
            noise(3);
        end

        // Final stretch without idling on either side
        src_idle_on = 1'b0;
        dst_idle_on = 1'b0;
        apply_config(8'd1, 16'($urandom_range(2, 6)), 16'($urandom_range(1, 5)));
        run_phase(80);
        drain_results();
        repeat (10) @(negedge clk);

        if (sb.pending_count() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending_count()));
        $display("covered %0d requests, %0d results checked: %0d bytes stored, %0d frames ready,",
                 sb.requests, sb.checked, sb.ev_count[int'(rtu_ftc_pkg::EV_BYTE_STORED)],
                 sb.ev_count[int'(rtu_ftc_pkg::EV_FRAME_READY)]);
        $display("  %0d rejected, %0d line errors, %0d tx fetches, %0d replies done",
                 sb.ev_count[int'(rtu_ftc_pkg::EV_REJECTED)],
                 sb.ev_count[int'(rtu_ftc_pkg::EV_LINE_ERROR)],
                 sb.ev_count[int'(rtu_ftc_pkg::EV_FETCH_TX)],
                 sb.ev_count[int'(rtu_ftc_pkg::EV_TX_DONE)]);
        if (sb.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/rtu_ftc_pkg.sv
hw/rtl/rtu_frame_timing_controller.sv
verif/tb.sv
